// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file mra_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/mra_pkg.sv -----
// types and constants of the modular residue accumulator
package mra_pkg;

    localparam int RES_W = 31;
    localparam int ACT_W = 3;
    localparam int SUM_W = RES_W + 1;

    localparam logic [ACT_W-1:0] ACT_LOAD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CMP  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OP_RED,
        ST_OP_NEG,
        ST_PRI_RED,
        ST_ARITH,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/mra_if.sv -----
// handshake channels of the modular residue accumulator

interface mra_req_if #(
    parameter int DATA_WIDTH = 32
);
    import mra_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ACT_W-1:0]             action;
    logic signed [DATA_WIDTH-1:0] operand;

    modport source (output valid, action, operand, input ready);
    modport sink   (input valid, action, operand, output ready);
endinterface

interface mra_rsp_if;
    import mra_pkg::*;

    logic             valid;
    logic             ready;
    logic [RES_W-1:0] residue;
    logic [RES_W-1:0] prior_residue;
    logic             is_equal;
    logic             is_below;

    modport source (output valid, residue, prior_residue, is_equal, is_below, input ready);
    modport sink   (input valid, residue, prior_residue, is_equal, is_below, output ready);
endinterface

interface mra_cfg_if;
    import mra_pkg::*;

    logic             valid;
    logic             ready;
    logic [RES_W-1:0] modulus;

    modport source (output valid, modulus, input ready);
    modport sink   (input valid, modulus, output ready);
endinterface

// ----- rtl/modular_residue_accumulator_unit.sv -----
// top level of the modular residue accumulator
//
// Channels: req carries action and signed operand, rsp returns the new residue,
// the prior residue and the compare flags, cfg writes the modulus (0 acts as 1).
// cfg is always ready; write it only while no request is in flight.
// One request is worked at a time; req.ready is high only while the sequencer
// is idle. All reductions go bit by bit through one conditional subtractor:
//   operand reduction     bit by bit, plus a sign fix-up step
//   prior residue reduce  (add, subtract, multiply only)
//   add / subtract        a final add or subtract step
//   multiply              double then add, per operand bit
// The next request can be taken in the same cycle that rsp.valid rises.
// The result sits in an output register, so a new request is taken while it
// waits; if rsp stalls, the next result holds in the final state till the old one is taken.
// Reset: modulus 1, residue 0, no result pending.
module modular_residue_accumulator_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    mra_req_if.sink   req,
    mra_rsp_if.source rsp,
    mra_cfg_if.sink   cfg
);
    import mra_pkg::*;

    localparam int SH_W  = (DATA_WIDTH > RES_W) ? DATA_WIDTH : RES_W;
    localparam int CNT_W = $clog2(SH_W);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SH_W-1:0]    sh_reg, sh_next;
    logic [RES_W-1:0]   acc_reg, acc_next;
    logic [RES_W-1:0]   op_reg, op_next;
    logic [RES_W-1:0]   pm_reg, pm_next;
    logic [RES_W-1:0]   m_reg, m_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic               neg_reg, neg_next;
    logic [RES_W-1:0]   mod_reg, mod_next;
    logic [RES_W-1:0]   prior_reg, prior_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic [RES_W-1:0]   rprior_reg, rprior_next;
    logic               eq_reg, eq_next;
    logic               below_reg, below_next;

    logic [DATA_WIDTH-1:0] op_raw;
    logic [DATA_WIDTH-1:0] op_mag;
    logic [RES_W-1:0]      mod_eff;
    logic [SUM_W-1:0]      unit_a;
    logic [RES_W-1:0]      unit_r;
    logic [RES_W-1:0]      now_val;
    logic                  accept;
    logic                  out_free;
    logic                  last_step;

    assign op_raw    = req.operand;
    assign op_mag    = op_raw[DATA_WIDTH-1] ? (~op_raw + DATA_WIDTH'(1)) : op_raw;
    assign mod_eff   = (mod_reg == '0) ? RES_W'(1) : mod_reg;
    assign accept    = req.valid && (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign last_step = (cnt_reg == '0);

    assign req.ready         = (state_reg == ST_IDLE);
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.residue       = res_reg;
    assign rsp.prior_residue = rprior_reg;
    assign rsp.is_equal      = eq_reg;
    assign rsp.is_below      = below_reg;

    mra_csub u_csub (
        .a (unit_a),
        .m (m_reg),
        .r (unit_r)
    );

    always_comb
    begin
        case (state_reg)
            ST_OP_RED, ST_PRI_RED:
                unit_a = {acc_reg, sh_reg[SH_W-1]};
            ST_OP_NEG:
                unit_a = {m_reg, 1'b0} - {1'b0, acc_reg};
            ST_ARITH:
                if (act_reg == ACT_ADD)
                    unit_a = {1'b0, acc_reg} + {1'b0, op_reg};
                else
                    unit_a = {1'b0, acc_reg} + {1'b0, m_reg} - {1'b0, op_reg};
            ST_MUL_DBL:
                unit_a = {acc_reg, 1'b0};
            ST_MUL_ADD:
                unit_a = {1'b0, acc_reg} + {1'b0, pm_reg};
            default:
                unit_a = '0;
        endcase
    end

    always_comb
    begin
        case (act_reg)
            ACT_LOAD:                  now_val = op_reg;
            ACT_ADD, ACT_SUB, ACT_MUL: now_val = acc_reg;
            default:                   now_val = prior_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_OP_RED;
            ST_OP_RED:
                if (last_step)
                    state_next = ST_OP_NEG;
            ST_OP_NEG:
                if (act_reg == ACT_ADD || act_reg == ACT_SUB || act_reg == ACT_MUL)
                    state_next = ST_PRI_RED;
                else
                    state_next = ST_FINISH;
            ST_PRI_RED:
                if (last_step)
                    state_next = (act_reg == ACT_MUL) ? ST_MUL_DBL : ST_ARITH;
            ST_ARITH:
                state_next = ST_FINISH;
            ST_MUL_DBL:
                state_next = ST_MUL_ADD;
            ST_MUL_ADD:
                state_next = last_step ? ST_FINISH : ST_MUL_DBL;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        sh_next        = sh_reg;
        acc_next       = acc_reg;
        op_next        = op_reg;
        pm_next        = pm_reg;
        m_next         = m_reg;
        act_next       = act_reg;
        neg_next       = neg_reg;
        mod_next       = mod_reg;
        prior_next     = prior_reg;
        rsp_valid_next = rsp_valid_reg;
        res_next       = res_reg;
        rprior_next    = rprior_reg;
        eq_next        = eq_reg;
        below_next     = below_reg;

        if (cfg.valid)
            mod_next = cfg.modulus;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    act_next = req.action;
                    neg_next = op_raw[DATA_WIDTH-1];
                    sh_next  = SH_W'(op_mag) << (SH_W - DATA_WIDTH);
                    acc_next = '0;
                    cnt_next = CNT_W'(DATA_WIDTH - 1);
                    m_next   = mod_eff;
                end
            ST_OP_RED, ST_PRI_RED:
            begin
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                acc_next = unit_r;
                if (state_reg == ST_PRI_RED && last_step && act_reg == ACT_MUL)
                begin
                    pm_next  = unit_r;
                    acc_next = '0;
                    sh_next  = SH_W'(op_reg) << (SH_W - RES_W);
                    cnt_next = CNT_W'(RES_W - 1);
                end
            end
            ST_OP_NEG:
            begin
                op_next  = (neg_reg && acc_reg != '0) ? unit_r : acc_reg;
                acc_next = '0;
                sh_next  = SH_W'(prior_reg) << (SH_W - RES_W);
                cnt_next = CNT_W'(RES_W - 1);
            end
            ST_ARITH, ST_MUL_DBL:
                acc_next = unit_r;
            ST_MUL_ADD:
            begin
                if (sh_reg[SH_W-1])
                    acc_next = unit_r;
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_FINISH:
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    res_next       = now_val;
                    rprior_next    = prior_reg;
                    eq_next        = (act_reg == ACT_CMP) && (op_reg == prior_reg);
                    below_next     = (act_reg == ACT_CMP) && (prior_reg < op_reg);
                    prior_next     = now_val;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mod_reg       <= RES_W'(1);
            prior_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mod_reg       <= mod_next;
            prior_reg     <= prior_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg     <= sh_next;
        acc_reg    <= acc_next;
        op_reg     <= op_next;
        pm_reg     <= pm_next;
        m_reg      <= m_next;
        act_reg    <= act_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
        rprior_reg <= rprior_next;
        eq_reg     <= eq_next;
        below_reg  <= below_next;
    end

endmodule

// ----- rtl/mra_csub.sv -----
// shared conditional subtract of the modulus, the one reduction unit of the block
module mra_csub (
    input  logic [mra_pkg::SUM_W-1:0] a,
    input  logic [mra_pkg::RES_W-1:0] m,
    output logic [mra_pkg::RES_W-1:0] r
);
    import mra_pkg::*;

    logic [SUM_W:0] diff;

    // a is below 2m wherever the result is used, so one subtract brings it into range
    assign diff = {1'b0, a} - {2'b00, m};
    assign r    = diff[SUM_W] ? a[RES_W-1:0] : diff[RES_W-1:0];

endmodule

// ----- rtl/mra_checker.sv -----
// port-level checks of the modular residue accumulator and their bind
`include "assert_macros.svh"

module mra_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [mra_pkg::RES_W-1:0] rsp_residue,
    input logic [mra_pkg::RES_W-1:0] rsp_prior_residue,
    input logic                      rsp_is_equal,
    input logic                      rsp_is_below
);
    import mra_pkg::*;

    // a stalled result beat stays offered, with residue and prior residue unchanged
    `CHK_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `CHK_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready,
        $stable(rsp_residue) && $stable(rsp_prior_residue))
    // compare flags are exclusive
    `CHK_IMPLY(a_flags_excl, clk, rst_n, rsp_valid, !(rsp_is_equal && rsp_is_below))
    // one request at a time; an accept is followed by req_ready low and no rise of rsp_valid
    `CHK_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready,
        !req_ready && !$rose(rsp_valid))

endmodule

bind modular_residue_accumulator_unit mra_checker u_mra_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_residue       (rsp.residue),
    .rsp_prior_residue (rsp.prior_residue),
    .rsp_is_equal      (rsp.is_equal),
    .rsp_is_below      (rsp.is_below)
);
